@@ rtl/frac_pkg.sv @@
// Shared types and constants for the fraction ALU.
`default_nettype none
package frac_pkg;
   localparam int OpW = 16;
   localparam int ProdW = 2 * OpW;
   localparam int NumW = ProdW + 1;
   localparam int DenW = 31;

   localparam logic [1:0] MODE_ADD = 2'd0;
   localparam logic [1:0] MODE_SUB = 2'd1;
   localparam logic [1:0] MODE_MUL = 2'd2;
   localparam logic [1:0] MODE_DIV = 2'd3;

   // raw signed pair handed from front to back
   typedef struct packed {
      logic            neg;
      logic [NumW-1:0] num_mag;
      logic [NumW-1:0] den_mag;
   } raw_type;
endpackage
`default_nettype wire

@@ rtl/fraction_alu_with_reduction.sv @@
// Top level of the fraction ALU with GCD reduction.
//  channel   ports                       direction
//  request   req_push/req_full, fields   in
//  response  rsp_pop/rsp_empty, fields   out
// An item passes the front-end states MUL1, MUL2, SUM and OUT, then the queue. The back end
// then runs binary-GCD steps and two restoring divisions, numerator then denominator;
// a zero raw denominator skips both. The GCD loop and the divider set the rate;
// the front end and the two-entry queue take following items meanwhile. Reset is
// synchronous and empties everything. A held result stalls the back end first, then the
// queue and the front end, and req_full stays high until the result is popped.
`default_nettype none
module fraction_alu_with_reduction (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_push,
   output logic                    req_full,
   input  wire  [1:0]              req_mode,
   input  wire  [frac_pkg::OpW-1:0]  req_a_num,
   input  wire  [frac_pkg::OpW-1:0]  req_a_den,
   input  wire  [frac_pkg::OpW-1:0]  req_b_num,
   input  wire  [frac_pkg::OpW-1:0]  req_b_den,
   output logic                    rsp_empty,
   input  wire                     rsp_pop,
   output logic [frac_pkg::NumW-1:0] rsp_res_num,
   output logic [frac_pkg::DenW-1:0] rsp_res_den,
   output logic                    rsp_invalid
);
   import frac_pkg::*;
   raw_type f_raw, q_raw;
   logic f_valid, f_ready, q_valid, q_ready;

   frac_front u_front (
      .clock, .reset, .push(req_push), .full(req_full), .mode(req_mode),
      .a_num(req_a_num), .a_den(req_a_den), .b_num(req_b_num), .b_den(req_b_den),
      .raw_valid(f_valid), .raw_ready(f_ready), .raw(f_raw)
   );
   frac_queue u_queue (
      .clock, .reset, .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_raw),
      .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_raw)
   );
   frac_back u_back (
      .clock, .reset, .raw_valid(q_valid), .raw_ready(q_ready), .raw(q_raw),
      .rsp_empty, .rsp_pop, .res_num(rsp_res_num), .res_den(rsp_res_den),
      .invalid(rsp_invalid)
   );
endmodule
`default_nettype wire

@@ rtl/frac_front.sv @@
// Front end: cross-multiplies operands into a signed raw numerator and denominator.
`default_nettype none
module frac_front (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    push,
   output logic                   full,
   input  wire  [1:0]             mode,
   input  wire  [frac_pkg::OpW-1:0] a_num,
   input  wire  [frac_pkg::OpW-1:0] a_den,
   input  wire  [frac_pkg::OpW-1:0] b_num,
   input  wire  [frac_pkg::OpW-1:0] b_den,
   output logic                   raw_valid,
   input  wire                    raw_ready,
   output frac_pkg::raw_type      raw
);
   import frac_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL1 = 3'd1;
   localparam logic [2:0] ST_MUL2 = 3'd2;
   localparam logic [2:0] ST_SUM  = 3'd3;
   localparam logic [2:0] ST_OUT  = 3'd4;

   logic [2:0] state_ff, state_in;
   logic [1:0] mode_ff;
   logic signed [OpW-1:0] an_ff, ad_ff, bn_ff, bd_ff;
   logic signed [ProdW:0] p1_ff, p2_ff, den_ff;
   logic signed [NumW:0] sum;
   logic signed [ProdW:0] mul_a, mul_b;

   assign full = state_ff != ST_IDLE;
   assign raw_valid = state_ff == ST_OUT;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (push) state_in = ST_MUL1;
         ST_MUL1: state_in = ST_MUL2;
         ST_MUL2: state_in = ST_SUM;
         ST_SUM:  state_in = ST_OUT;
         ST_OUT:  if (raw_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // one multiplier pair per cycle, each registered
   always_comb begin
      mul_a = (ProdW+1)'(an_ff * bd_ff);
      mul_b = (ProdW+1)'(bn_ff * ad_ff);
      if (state_ff == ST_MUL2) begin
         mul_a = (ProdW+1)'(ad_ff * bd_ff);
         mul_b = (ProdW+1)'(an_ff * bn_ff);
         if (mode_ff == MODE_DIV) begin
            mul_a = (ProdW+1)'(ad_ff * bn_ff);
            mul_b = (ProdW+1)'(an_ff * bd_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && push) begin
         mode_ff <= mode;
         an_ff <= a_num;
         ad_ff <= a_den;
         bn_ff <= b_num;
         bd_ff <= b_den;
      end
      if (state_ff == ST_MUL1) begin
         p1_ff <= mul_a;
         p2_ff <= mul_b;
      end
      if (state_ff == ST_MUL2) begin
         den_ff <= mul_a;
         if (mode_ff == MODE_MUL || mode_ff == MODE_DIV) begin
            p1_ff <= mul_b;
            p2_ff <= '0;
         end
      end
   end

   always_comb begin
      if (mode_ff == MODE_SUB) sum = (NumW+1)'(p1_ff) - (NumW+1)'(p2_ff);
      else if (mode_ff == MODE_ADD) sum = (NumW+1)'(p1_ff) + (NumW+1)'(p2_ff);
      else sum = (NumW+1)'(p1_ff);
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_SUM) begin
         raw.num_mag <= sum[NumW] ? NumW'(-sum) : sum[NumW-1:0];
         raw.den_mag <= den_ff[ProdW] ? NumW'(-den_ff) : NumW'(den_ff);
         raw.neg <= sum[NumW] ^ den_ff[ProdW];
      end
   end
endmodule
`default_nettype wire

@@ rtl/frac_queue.sv @@
// Two-entry queue between front and back ends.
`default_nettype none
module frac_queue (
   input  wire                clock,
   input  wire                reset,
   input  wire                wr_valid,
   output logic               wr_ready,
   input  frac_pkg::raw_type  wr_data,
   output logic               rd_valid,
   input  wire                rd_ready,
   output frac_pkg::raw_type  rd_data
);
   import frac_pkg::*;
   raw_type mem_ff [2];
   logic wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic wr, rd;

   assign wr_ready = cnt_ff != 2'd2;
   assign rd_valid = cnt_ff != 2'd0;
   assign rd_data = mem_ff[rp_ff];
   assign wr = wr_valid && wr_ready;
   assign rd = rd_valid && rd_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (wr) wp_ff <= ~wp_ff;
         if (rd) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + 2'(wr) - 2'(rd);
      end
   end

   always_ff @(posedge clock) begin
      if (wr) mem_ff[wp_ff] <= wr_data;
   end
endmodule
`default_nettype wire

@@ rtl/frac_back.sv @@
// Back end: binary GCD, two restoring divisions and sign fix-up.
`default_nettype none
module frac_back (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   raw_valid,
   output logic                  raw_ready,
   input  frac_pkg::raw_type     raw,
   output logic                  rsp_empty,
   input  wire                   rsp_pop,
   output logic [frac_pkg::NumW-1:0] res_num,
   output logic [frac_pkg::DenW-1:0] res_den,
   output logic                  invalid
);
   import frac_pkg::*;
   localparam int CntW = $clog2(NumW + 1);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_GCD  = 3'd1;
   localparam logic [2:0] ST_DIVN = 3'd2;
   localparam logic [2:0] ST_DIVD = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   logic [2:0] state_ff;
   logic neg_ff;
   logic [NumW-1:0] nm_ff, dm_ff, u_ff, v_ff, g_ff, q_ff, qn_ff;
   logic [NumW:0] rem_ff;
   logic [CntW-1:0] sh_ff, bit_ff;
   logic [NumW-1:0] dividend;
   logic [NumW:0] trial;
   logic out_full_ff;
   logic [NumW-1:0] sgn_num;

   assign raw_ready = state_ff == ST_IDLE;
   assign rsp_empty = !out_full_ff;
   assign dividend = (state_ff == ST_DIVN) ? nm_ff : dm_ff;
   assign trial = {rem_ff[NumW-1:0], dividend[bit_ff]};
   assign sgn_num = (neg_ff && qn_ff != '0) ? -qn_ff : qn_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         out_full_ff <= 1'b0;
      end else begin
         // in ST_DONE the output register is handled by the load below
         if (rsp_pop && out_full_ff && state_ff != ST_DONE) out_full_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (raw_valid) begin
                  neg_ff <= raw.neg;
                  nm_ff <= raw.num_mag;
                  dm_ff <= raw.den_mag;
                  u_ff <= raw.num_mag;
                  v_ff <= raw.den_mag;
                  sh_ff <= '0;
                  if (raw.den_mag == '0) begin
                     qn_ff <= '0;
                     q_ff <= '0;
                     state_ff <= ST_DONE;
                  end else if (raw.num_mag == '0) begin
                     g_ff <= raw.den_mag;
                     rem_ff <= '0;
                     bit_ff <= CntW'(NumW - 1);
                     state_ff <= ST_DIVN;
                  end else begin
                     state_ff <= ST_GCD;
                  end
               end
            end
            ST_GCD: begin
               // binary GCD, one step per cycle
               if (u_ff == v_ff) begin
                  g_ff <= u_ff << sh_ff;
                  rem_ff <= '0;
                  bit_ff <= CntW'(NumW - 1);
                  state_ff <= ST_DIVN;
               end else if (!u_ff[0] && !v_ff[0]) begin
                  u_ff <= u_ff >> 1;
                  v_ff <= v_ff >> 1;
                  sh_ff <= sh_ff + CntW'(1);
               end else if (!u_ff[0]) begin
                  u_ff <= u_ff >> 1;
               end else if (!v_ff[0]) begin
                  v_ff <= v_ff >> 1;
               end else if (u_ff > v_ff) begin
                  u_ff <= (u_ff - v_ff) >> 1;
               end else begin
                  v_ff <= (v_ff - u_ff) >> 1;
               end
            end
            ST_DIVN, ST_DIVD: begin
               if (bit_ff == '0) begin
                  rem_ff <= '0;
                  bit_ff <= CntW'(NumW - 1);
                  if (state_ff == ST_DIVN) begin
                     qn_ff <= {q_ff[NumW-2:0], trial >= {1'b0, g_ff}};
                     state_ff <= ST_DIVD;
                  end else begin
                     q_ff <= {q_ff[NumW-2:0], trial >= {1'b0, g_ff}};
                     state_ff <= ST_DONE;
                  end
               end else begin
                  bit_ff <= bit_ff - CntW'(1);
                  q_ff <= {q_ff[NumW-2:0], trial >= {1'b0, g_ff}};
                  if (trial >= {1'b0, g_ff}) begin
                     rem_ff <= trial - {1'b0, g_ff};
                  end else begin
                     rem_ff <= trial;
                  end
               end
            end
            ST_DONE: begin
               if (!out_full_ff || rsp_pop) begin
                  res_num <= sgn_num;
                  res_den <= q_ff[DenW-1:0];
                  invalid <= dm_ff == '0;
                  out_full_ff <= 1'b1;
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

@@ rtl/frac_checker.sv @@
// Port-level checks for the fraction ALU, bound to the top level.
`default_nettype none
module frac_checker (
   input wire clock,
   input wire reset,
   input wire req_push,
   input wire req_full,
   input wire rsp_empty,
   input wire rsp_pop,
   input wire [frac_pkg::NumW-1:0] rsp_res_num,
   input wire [frac_pkg::DenW-1:0] rsp_res_den,
   input wire rsp_invalid
);
   a_inv_zero: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_invalid |-> rsp_res_num == '0 && rsp_res_den == '0)
      else $error("invalid result with nonzero fields");
   a_den_pos: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_invalid |-> rsp_res_den != '0)
      else $error("valid result with zero denominator");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_res_num))
      else $error("result changed while waiting");
   // front end is busy right after it takes a transaction
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_push && !req_full |=> req_full)
      else $error("input ready right after a transaction");
   a_rst: assert property (@(posedge clock) $past(reset) |-> rsp_empty)
      else $error("result present after reset");
endmodule

bind fraction_alu_with_reduction frac_checker u_chk (.*);
`default_nettype wire
